// ----- hw/rtl/qrk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrk_pkg: shared types and helpers for the song queue
// Sizes, operation codes, controller states and ring arithmetic used by the
// queue controller and the top level.
// ----------------------------------------------------------------------------
package qrk_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W     = CNT_W + 1;
  localparam int unsigned REF_W     = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned OUT_CNT_W = 5;
  localparam int unsigned ENTRY_W   = REF_W + ID_W;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_REMOVE     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]  song_id;
    logic [REF_W-1:0] song_ref;
  } entry_t;

  typedef struct packed {
    logic                 overflow;
    logic                 is_empty;
    logic [OUT_CNT_W-1:0] entry_count;
    logic [OUT_CNT_W-1:0] removed_count;
    logic                 popped_valid;
    logic [ID_W-1:0]      popped_id;
    logic [REF_W-1:0]     popped_ref;
  } res_t;

  // Ring position of base + off; valid for base < DEPTH and off < DEPTH.
  function automatic idx_t ring_add(idx_t base, cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return IDX_W'(sum);
  endfunction

  function automatic idx_t ring_dec(idx_t base);
    idx_t res;
    if (base == '0) begin
      res = IDX_W'(DEPTH - 1);
    end else begin
      res = base - 1'b1;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/queue_with_remove_by_key.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_with_remove_by_key: bounded song queue with delete by identifier
// Sixteen-entry double-ended queue of (handle, identifier) pairs held in a
// ring in one synchronous RAM. Every request gives exactly one result.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the operation code
//   (push back, push front, pop front, clear, remove by identifier) and tdata
//   the song handle and identifier. Results leave on the m_axis channel and
//   report the popped entry, the number removed, the entry count after the
//   request, an empty flag and an overflow flag for a dropped push.
//   Requests are handled one at a time. For push, pop, clear and unused codes
//   the request is executed in the cycle it is accepted, and its result is
//   offered to the output register. A remove walks the held entries through
//   the RAM read port, one per cycle, and compacts the survivors in place
//   through the write port; a remove on an empty queue goes straight to the
//   result. The result reaches m_axis through the output register. Reset
//   empties the queue (head and count to zero); the RAM contents are not
//   cleared, as only written entries are ever read. When the receiver stalls,
//   the output register holds the result and one further request may be
//   accepted and executed; the controller then waits with its result until
//   the output register is free.
// ----------------------------------------------------------------------------
module queue_with_remove_by_key (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // song_ref [15:0], song_id [31:16]
  input  logic [2:0]  s_axis_tuser,   // operation [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // popped_ref [15:0], popped_id [31:16],
                                      // popped_valid [32], removed_count [37:33],
                                      // entry_count [42:38], is_empty [43],
                                      // overflow [44], zero [47:45]
);
  import qrk_pkg::*;

  entry_t in_entry;
  res_t   res;
  res_t   out_q;
  logic   res_valid;
  logic   res_ready;
  logic   out_valid_q;
  logic   mem_we;
  idx_t   mem_waddr;
  entry_t mem_wdata;
  logic   mem_re;
  idx_t   mem_raddr;
  entry_t mem_rdata;

  assign in_entry.song_ref = s_axis_tdata[15:0];
  assign in_entry.song_id  = s_axis_tdata[31:16];

  qrk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_entry_i  (in_entry),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  qrk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The output register takes a new result when empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

  // The controller never takes a request while it is offering a result.
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && res_valid))
    else $error("request accepted while a result is pending");

  // The reported count never exceeds the ring size and matches the empty flag.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> ((res.entry_count <= OUT_CNT_W'(DEPTH)) &&
                   (res.is_empty == (res.entry_count == '0))))
    else $error("entry count out of range or inconsistent with empty flag");

  // A successful pop neither removes by key nor overflows.
  a_pop_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.popped_valid) |-> ((res.removed_count == '0) && !res.overflow))
    else $error("pop result carries remove or overflow information");

  // A result handed over while the output register is busy would be lost.
  a_no_result_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && res_valid) |=> (out_valid_q && res_valid))
    else $error("pending result dropped while output stalled");

endmodule

// ----- hw/rtl/qrk_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrk_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and only
// updated when a read is requested.
// ----------------------------------------------------------------------------
module qrk_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/qrk_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrk_ctrl: queue controller
// Holds head and count, drives the entry memory and runs the compaction scan
// for remove-by-identifier.
// ----------------------------------------------------------------------------
module qrk_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [qrk_pkg::OP_W-1:0] in_op_i,
  input  qrk_pkg::entry_t         in_entry_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output qrk_pkg::res_t           res_o,
  output logic                    mem_we_o,
  output qrk_pkg::idx_t           mem_waddr_o,
  output qrk_pkg::entry_t         mem_wdata_o,
  output logic                    mem_re_o,
  output qrk_pkg::idx_t           mem_raddr_o,
  input  qrk_pkg::entry_t         mem_rdata_i
);
  import qrk_pkg::*;

  state_e            state_q, state_d;
  idx_t              head_q, head_d;
  cnt_t              count_q, count_d;
  cnt_t              rd_q, rd_d;
  cnt_t              wr_q, wr_d;
  cnt_t              removed_q, removed_d;
  logic              chk_q, chk_d;
  logic              pop_hit_q, pop_hit_d;
  logic              ovf_q, ovf_d;
  logic [ID_W-1:0]   key_q, key_d;
  logic              in_fire;
  logic              full;
  logic              scan_last;
  logic              key_hit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q >= CNT_W'(DEPTH));
  assign scan_last  = chk_q && (rd_q == count_q);
  assign key_hit    = (mem_rdata_i.song_id == key_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if ((op_e'(in_op_i) == OP_REMOVE) && (count_q != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    removed_d   = removed_q;
    chk_d       = 1'b0;
    pop_hit_d   = pop_hit_q;
    ovf_d       = ovf_q;
    key_d       = key_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = in_entry_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    res_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          pop_hit_d = 1'b0;
          ovf_d     = 1'b0;
          removed_d = '0;
          rd_d      = '0;
          wr_d      = '0;
          key_d     = in_entry_i.song_id;
          case (op_e'(in_op_i))
            OP_PUSH_BACK: begin
              if (full) begin
                ovf_d = 1'b1;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = ring_add(head_q, count_q);
                count_d     = count_q + 1'b1;
              end
            end
            OP_PUSH_FRONT: begin
              if (full) begin
                ovf_d = 1'b1;
              end else begin
                head_d      = ring_dec(head_q);
                mem_we_o    = 1'b1;
                mem_waddr_o = ring_dec(head_q);
                count_d     = count_q + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (count_q != '0) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = head_q;
                pop_hit_d   = 1'b1;
                head_d      = ring_add(head_q, CNT_W'(1));
                count_d     = count_q - 1'b1;
              end
            end
            OP_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Reads run one entry ahead of the compare; the write offset never
        // passes the read offset, so no entry is read after being overwritten.
        if (rd_q < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ring_add(head_q, rd_q);
          rd_d        = rd_q + 1'b1;
          chk_d       = 1'b1;
        end
        if (chk_q) begin
          if (key_hit) begin
            removed_d = removed_q + 1'b1;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = ring_add(head_q, wr_q);
            mem_wdata_o = mem_rdata_i;
            wr_d        = wr_q + 1'b1;
          end
        end
        if (scan_last) begin
          count_d = key_hit ? wr_q : wr_q + 1'b1;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o               = '0;
    res_o.popped_valid  = pop_hit_q;
    res_o.popped_ref    = pop_hit_q ? mem_rdata_i.song_ref : '0;
    res_o.popped_id     = pop_hit_q ? mem_rdata_i.song_id : '0;
    res_o.removed_count = OUT_CNT_W'(removed_q);
    res_o.entry_count   = OUT_CNT_W'(count_q);
    res_o.is_empty      = (count_q == '0);
    res_o.overflow      = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      rd_q      <= '0;
      wr_q      <= '0;
      removed_q <= '0;
      chk_q     <= 1'b0;
      pop_hit_q <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      rd_q      <= rd_d;
      wr_q      <= wr_d;
      removed_q <= removed_d;
      chk_q     <= chk_d;
      pop_hit_q <= pop_hit_d;
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule
